### hdl/tpfl_pkg.sv
// shared types and constants for the tlv packet field locator
// no dependencies
package tpfl_pkg;

    // record kinds
    localparam logic [3:0] K_HOPLIMIT  = 4'd0;
    localparam logic [3:0] K_LIFETIME  = 4'd1;
    localparam logic [3:0] K_CACHETIME = 4'd2;
    localparam logic [3:0] K_NAME      = 4'd3;
    localparam logic [3:0] K_KEYID     = 4'd4;
    localparam logic [3:0] K_OBJHASH   = 4'd5;
    localparam logic [3:0] K_EXPIRY    = 4'd6;
    localparam logic [3:0] K_CPI       = 4'd7;
    localparam logic [3:0] K_FRAGMENT  = 4'd8;
    localparam logic [3:0] K_CERT      = 4'd9;
    localparam logic [3:0] K_PUBKEY    = 4'd10;
    localparam logic [3:0] K_DONE      = 4'd11;

    // done status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_VER   = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_SHORT_HDR = 3'd3;
    localparam logic [2:0] ST_LEN_BELOW = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // tlv type codes
    localparam logic [15:0] T_ZERO  = 16'h0000;
    localparam logic [15:0] T_01    = 16'h0001;
    localparam logic [15:0] T_02    = 16'h0002;
    localparam logic [15:0] T_03    = 16'h0003;
    localparam logic [15:0] T_05    = 16'h0005;
    localparam logic [15:0] T_06    = 16'h0006;
    localparam logic [15:0] T_07    = 16'h0007;
    localparam logic [15:0] T_08    = 16'h0008;
    localparam logic [15:0] T_09    = 16'h0009;
    localparam logic [15:0] T_0B    = 16'h000B;
    localparam logic [15:0] T_0C    = 16'h000C;
    localparam logic [15:0] T_CPI   = 16'hBEEF;
    localparam logic [7:0]  PT_A4   = 8'hA4;

    // output queue depth
    localparam int unsigned OUT_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [15:0] field_offset;
        logic [15:0] field_length;
        logic [7:0]  packet_kind;
        logic [2:0]  parse_status;
        logic        last_of_packet;
    } t_rec;

endpackage

### hdl/tpfl_if.sv
// valid/ready channel interfaces for packet bytes and field records
// no dependencies
interface tpfl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;
    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface tpfl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_kind;
    logic [15:0] field_offset;
    logic [15:0] field_length;
    logic [7:0]  packet_kind;
    logic [2:0]  parse_status;
    logic        last_of_packet;
    modport source (output valid, output record_kind, output field_offset,
                    output field_length, output packet_kind, output parse_status,
                    output last_of_packet, input ready);
    modport sink   (input valid, input record_kind, input field_offset,
                    input field_length, input packet_kind, input parse_status,
                    input last_of_packet, output ready);
endinterface

### hdl/tpfl_parser.sv
// parser state registers and per-byte next-state logic
// depends on tpfl_pkg
module tpfl_parser
    import tpfl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output logic       o_rec0_valid,
    output t_rec       o_rec0,
    output logic       o_rec1_valid,
    output t_rec       o_rec1
);

    typedef enum logic [9:0] {
        M_FIXED    = 10'b00_0000_0001,
        M_PERHOP   = 10'b00_0000_0010,
        M_MESSAGE  = 10'b00_0000_0100,
        M_INTEREST = 10'b00_0000_1000,
        M_OBJECT   = 10'b00_0001_0000,
        M_VALALG   = 10'b00_0010_0000,
        M_VALTYPE  = 10'b00_0100_0000,
        M_SIGPARAM = 10'b00_1000_0000,
        M_IDLE     = 10'b01_0000_0000,
        M_DISCARD  = 10'b10_0000_0000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [16:0] start;
    } t_walk;

    // step into a walk level, dropping through levels with no room for a tl header
    function automatic t_walk enter_level(t_mode mode, logic [17:0] start,
                                          logic [7:0] hend, logic [15:0] pend,
                                          logic [16:0] cend, logic [16:0] iend,
                                          logic [1:0] fc);
        t_walk       w;
        t_mode       m;
        logic [17:0] s;
        logic        stop;
        m    = mode;
        s    = start;
        stop = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!stop) begin
                unique case (m)
                    M_PERHOP: begin
                        if (s + 18'd4 < {10'd0, hend}) stop = 1'b1;
                        else begin
                            m = M_MESSAGE;
                            s = {10'd0, hend};
                        end
                    end
                    M_MESSAGE: begin
                        if (s + 18'd4 >= {2'd0, pend}) m = M_IDLE;
                        stop = 1'b1;
                    end
                    M_INTEREST: begin
                        if (fc < 2'd3 && s + 18'd4 <= {1'b0, cend}) stop = 1'b1;
                        else begin
                            m = M_VALALG;
                            s = {1'b0, cend};
                        end
                    end
                    M_OBJECT: begin
                        if (fc < 2'd2 && s + 18'd4 <= {1'b0, cend}) stop = 1'b1;
                        else begin
                            m = M_VALALG;
                            s = {1'b0, cend};
                        end
                    end
                    M_VALALG: begin
                        if (s + 18'd4 >= {2'd0, pend}) m = M_IDLE;
                        stop = 1'b1;
                    end
                    M_VALTYPE: begin
                        if (s + 18'd4 >= {1'b0, cend}) m = M_IDLE;
                        stop = 1'b1;
                    end
                    M_SIGPARAM: begin
                        if (s + 18'd4 >= {1'b0, iend}) m = M_IDLE;
                        stop = 1'b1;
                    end
                    default: stop = 1'b1;
                endcase
            end
        end
        w.mode  = m;
        w.start = s[16:0];
        return w;
    endfunction

    function automatic t_rec make_rec(logic [3:0] kind, logic [17:0] off,
                                      logic [15:0] len, logic [7:0] pk,
                                      logic [2:0] st);
        t_rec r;
        r.record_kind    = kind;
        r.field_offset   = off[15:0];
        r.field_length   = len;
        r.packet_kind    = pk;
        r.parse_status   = st;
        r.last_of_packet = (kind == K_DONE);
        return r;
    endfunction

    t_mode       r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_htb, n_htb;
    logic [7:0]  r_hend, n_hend;
    logic [15:0] r_pend, n_pend;
    logic [31:0] r_shift, n_shift;
    logic [1:0]  r_tlc, n_tlc;
    logic [16:0] r_start, n_start;
    logic [16:0] r_cend, n_cend;
    logic [16:0] r_iend, n_iend;
    logic [1:0]  r_fc, n_fc;
    logic [2:0]  r_err, n_err;

    logic        fld_v, done_v;
    t_rec        fld_rec, done_rec;
    logic        finished, new_pkt;
    logic [17:0] diff, v, e;
    logic [15:0] tt, ll;
    logic [3:0]  kk;
    logic        kk_v;
    t_walk       w;

    // per-byte parse step
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_htb   = r_htb;
        n_hend  = r_hend;
        n_pend  = r_pend;
        n_shift = r_shift;
        n_tlc   = r_tlc;
        n_start = r_start;
        n_cend  = r_cend;
        n_iend  = r_iend;
        n_fc    = r_fc;
        n_err   = r_err;
        fld_v    = 1'b0;
        done_v   = 1'b0;
        fld_rec  = '0;
        done_rec = '0;
        finished = 1'b0;
        new_pkt  = 1'b0;
        diff = {2'd0, r_pos} - {1'b0, r_start};
        v    = '0;
        e    = '0;
        tt   = '0;
        ll   = '0;
        kk   = K_NAME;
        kk_v = 1'b0;
        w    = '0;

        if (r_mode == M_DISCARD) begin
            finished = 1'b1;
            new_pkt  = i_frame_end;
        end else if (r_mode == M_FIXED) begin
            // fixed header bytes
            if (r_pos == 16'd0 && i_data_byte != 8'd1) n_err = ST_BAD_VER;
            else if (r_pos == 16'd1) n_htb = i_data_byte;
            else if (r_pos == 16'd2) n_pend = {i_data_byte, 8'd0};
            else if (r_pos == 16'd3) n_pend = {r_pend[15:8], i_data_byte};
            else if (r_pos == 16'd7) begin
                n_hend = i_data_byte;
                if (r_err == ST_OK) begin
                    if (!(r_htb == 8'd0 || r_htb == 8'd1 || r_htb == 8'd2 ||
                          r_htb == 8'd4 || r_htb == PT_A4))
                        n_err = ST_BAD_TYPE;
                    else if (i_data_byte < 8'd8) n_err = ST_SHORT_HDR;
                    else if (r_pend < {8'd0, i_data_byte}) n_err = ST_LEN_BELOW;
                end
                if (n_err != ST_OK) begin
                    done_v   = 1'b1;
                    done_rec = make_rec(K_DONE, '0, '0, n_htb, n_err);
                    finished = 1'b1;
                    if (i_frame_end) new_pkt = 1'b1;
                    else n_mode = M_DISCARD;
                end else begin
                    if (r_htb == 8'd0) begin
                        fld_v   = 1'b1;
                        fld_rec = make_rec(K_HOPLIMIT, 18'd4, 16'd1, n_htb, ST_OK);
                    end
                    w = enter_level(M_PERHOP, 18'd8, n_hend, n_pend, r_cend, r_iend, r_fc);
                    n_mode  = w.mode;
                    n_start = w.start;
                    n_tlc   = 2'd0;
                end
            end
            if (!finished && n_mode == M_FIXED) begin
                finished = 1'b1;
                if (i_frame_end) begin
                    done_v   = 1'b1;
                    done_rec = make_rec(K_DONE, '0, '0, n_htb, ST_TRUNC);
                    new_pkt  = 1'b1;
                end else begin
                    n_pos = r_pos + 16'd1;
                end
            end
        end else if (r_mode != M_IDLE && {1'b0, r_pos} >= r_start && diff[17:2] == '0) begin
            // tl header byte
            n_tlc   = diff[1:0];
            n_shift = {r_shift[23:0], i_data_byte};
            if (diff[1:0] == 2'd3) begin
                tt = n_shift[31:16];
                ll = n_shift[15:0];
                v  = {1'b0, r_start} + 18'd4;
                e  = v + {2'd0, ll};
                unique case (r_mode)
                    M_PERHOP: begin
                        if (e <= {10'd0, r_hend}) begin
                            if (tt == T_01) begin
                                fld_v = 1'b1;
                                fld_rec = make_rec(K_LIFETIME, v, ll, r_htb, ST_OK);
                            end else if (tt == T_02) begin
                                fld_v = 1'b1;
                                fld_rec = make_rec(K_CACHETIME, v, ll, r_htb, ST_OK);
                            end
                        end
                        w = enter_level(M_PERHOP, e, r_hend, r_pend, r_cend, r_iend, r_fc);
                    end
                    M_MESSAGE: begin
                        if (e > {2'd0, r_pend}) begin
                            w.mode  = M_IDLE;
                            w.start = e[16:0];
                        end else begin
                            n_cend = e[16:0];
                            n_fc   = 2'd0;
                            if (tt == T_01)
                                w = enter_level(M_INTEREST, v, r_hend, r_pend, n_cend,
                                                r_iend, 2'd0);
                            else if (tt == T_02 || tt == T_06)
                                w = enter_level(M_OBJECT, v, r_hend, r_pend, n_cend,
                                                r_iend, 2'd0);
                            else begin
                                if (tt == T_CPI) begin
                                    fld_v = 1'b1;
                                    fld_rec = make_rec(K_CPI, v, ll, r_htb, ST_OK);
                                end else if (tt == T_05) begin
                                    fld_v = 1'b1;
                                    fld_rec = make_rec(K_FRAGMENT, v, ll, r_htb, ST_OK);
                                end
                                w = enter_level(M_VALALG, e, r_hend, r_pend, n_cend,
                                                r_iend, 2'd0);
                            end
                        end
                    end
                    M_INTEREST, M_OBJECT: begin
                        if (e <= {1'b0, r_cend}) begin
                            if (tt == T_ZERO) begin
                                kk = K_NAME; kk_v = 1'b1;
                            end else if (r_mode == M_INTEREST && tt == T_02) begin
                                kk = K_KEYID; kk_v = 1'b1;
                            end else if (r_mode == M_INTEREST && tt == T_03) begin
                                kk = K_OBJHASH; kk_v = 1'b1;
                            end else if (r_mode == M_OBJECT && tt == T_06) begin
                                kk = K_EXPIRY; kk_v = 1'b1;
                            end
                        end
                        if (kk_v) begin
                            fld_v   = 1'b1;
                            fld_rec = make_rec(kk, v, ll, r_htb, ST_OK);
                            n_fc    = r_fc + 2'd1;
                        end
                        w = enter_level(r_mode, e, r_hend, r_pend, r_cend, r_iend, n_fc);
                    end
                    M_VALALG: begin
                        if (e <= {2'd0, r_pend} && tt == T_03) begin
                            n_cend = e[16:0];
                            w = enter_level(M_VALTYPE, v, r_hend, r_pend, n_cend, r_iend, r_fc);
                        end else begin
                            w.mode  = M_IDLE;
                            w.start = e[16:0];
                        end
                    end
                    M_VALTYPE: begin
                        if (e <= {1'b0, r_cend} && (tt == T_06 || tt == T_07 || tt == T_08)) begin
                            n_iend = e[16:0];
                            w = enter_level(M_SIGPARAM, v, r_hend, r_pend, r_cend, n_iend, r_fc);
                        end else begin
                            w.mode  = M_IDLE;
                            w.start = e[16:0];
                        end
                    end
                    M_SIGPARAM: begin
                        if (e <= {1'b0, r_iend}) begin
                            if (tt == T_09) begin
                                fld_v = 1'b1;
                                fld_rec = make_rec(K_KEYID, v, ll, r_htb, ST_OK);
                            end else if (tt == T_0C) begin
                                fld_v = 1'b1;
                                fld_rec = make_rec(K_CERT, v, ll, r_htb, ST_OK);
                            end else if (tt == T_0B) begin
                                fld_v = 1'b1;
                                fld_rec = make_rec(K_PUBKEY, v, ll, r_htb, ST_OK);
                            end
                        end
                        w = enter_level(M_SIGPARAM, e, r_hend, r_pend, r_cend, r_iend, r_fc);
                    end
                    default: begin
                        w.mode  = r_mode;
                        w.start = r_start;
                    end
                endcase
                n_mode  = w.mode;
                n_start = w.start;
                n_tlc   = 2'd0;
            end
        end

        // packet end or early end
        if (!finished) begin
            if ({1'b0, r_pos} + 17'd1 == {1'b0, n_pend}) begin
                done_v   = 1'b1;
                done_rec = make_rec(K_DONE, '0, '0, n_htb, ST_OK);
                if (i_frame_end) new_pkt = 1'b1;
                else n_mode = M_DISCARD;
            end else if (i_frame_end) begin
                done_v   = 1'b1;
                done_rec = make_rec(K_DONE, '0, '0, n_htb, ST_TRUNC);
                new_pkt  = 1'b1;
            end else begin
                n_pos = r_pos + 16'd1;
            end
        end

        if (new_pkt) begin
            n_mode  = M_FIXED;
            n_pos   = '0;
            n_htb   = '0;
            n_hend  = '0;
            n_pend  = '0;
            n_shift = '0;
            n_tlc   = '0;
            n_start = '0;
            n_cend  = '0;
            n_iend  = '0;
            n_fc    = '0;
            n_err   = ST_OK;
        end
    end

    // field record first, done record after it
    assign o_rec0_valid = i_valid && (fld_v || done_v);
    assign o_rec0       = fld_v ? fld_rec : done_rec;
    assign o_rec1_valid = i_valid && fld_v && done_v;
    assign o_rec1       = done_rec;

    // state update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_FIXED;
            r_pos   <= '0;
            r_htb   <= '0;
            r_hend  <= '0;
            r_pend  <= '0;
            r_shift <= '0;
            r_tlc   <= '0;
            r_start <= '0;
            r_cend  <= '0;
            r_iend  <= '0;
            r_fc    <= '0;
            r_err   <= ST_OK;
        end else if (i_valid) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_htb   <= n_htb;
            r_hend  <= n_hend;
            r_pend  <= n_pend;
            r_shift <= n_shift;
            r_tlc   <= n_tlc;
            r_start <= n_start;
            r_cend  <= n_cend;
            r_iend  <= n_iend;
            r_fc    <= n_fc;
            r_err   <= n_err;
        end
    end

endmodule

### hdl/tpfl_out_fifo.sv
// small record queue taking up to two records per cycle, one out per cycle
// depends on tpfl_pkg
module tpfl_out_fifo
    import tpfl_pkg::*;
#(
    parameter int unsigned DEPTH = OUT_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push0,
    input  t_rec i_rec0,
    input  logic i_push1,
    input  t_rec i_rec1,
    output logic o_room2,
    output logic o_valid,
    output t_rec o_rec,
    input  logic i_pop
);

    localparam int unsigned AW = $clog2(DEPTH);

    t_rec              r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [AW:0]       r_cnt, n_cnt;
    logic              pop;
    logic [AW-1:0]     wr1;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign o_room2 = (r_cnt <= (AW + 1)'(DEPTH - 2));
    assign wr1     = r_wr + AW'(1);

    // occupancy
    always_comb begin
        n_cnt = r_cnt + (AW + 1)'(i_push0) + (AW + 1)'(i_push1) - (AW + 1)'(pop);
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) r_rd <= r_rd + AW'(1);
            if (i_push1) r_wr <= r_wr + AW'(2);
            else if (i_push0) r_wr <= wr1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wr] <= i_rec0;
        if (i_push1) r_mem[wr1] <= i_rec1;
    end

endmodule

### hdl/tlv_packet_field_locator_core.sv
// Output: records are written into the registered output queue as their byte is accepted.
// Throughput: one byte per cycle; a byte giving a field and a done record fills
// two slots of the 4-deep output queue, and input ready needs two free slots.
// Reset: synchronous active-low; parser returns to the fixed header, queue empties.
// depends on tpfl_pkg, tpfl_if, tpfl_parser, tpfl_out_fifo
module tlv_packet_field_locator_core
    import tpfl_pkg::*;
#(
    parameter int unsigned P_OUT_DEPTH = OUT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpfl_in_if.sink    i_in,
    tpfl_out_if.source o_out
);

    logic accept;
    logic room2;
    logic rec0_v, rec1_v, out_v;
    t_rec rec0, rec1, out_rec;

    assign i_in.ready = room2;
    assign accept     = i_in.valid && room2;

    // byte parser
    tpfl_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_data_byte  (i_in.data_byte),
        .i_frame_end  (i_in.frame_end),
        .o_rec0_valid (rec0_v),
        .o_rec0       (rec0),
        .o_rec1_valid (rec1_v),
        .o_rec1       (rec1)
    );

    // output record queue
    tpfl_out_fifo #(.DEPTH(P_OUT_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (rec0_v),
        .i_rec0  (rec0),
        .i_push1 (rec1_v),
        .i_rec1  (rec1),
        .o_room2 (room2),
        .o_valid (out_v),
        .o_rec   (out_rec),
        .i_pop   (o_out.ready)
    );

    assign o_out.valid          = out_v;
    assign o_out.record_kind    = out_rec.record_kind;
    assign o_out.field_offset   = out_rec.field_offset;
    assign o_out.field_length   = out_rec.field_length;
    assign o_out.packet_kind    = out_rec.packet_kind;
    assign o_out.parse_status   = out_rec.parse_status;
    assign o_out.last_of_packet = out_rec.last_of_packet;

endmodule

### tb/tlv_packet_field_locator_core_tb.sv
// testbench for the tlv packet field locator: streams packets, predicts field records
// depends on tpfl_pkg, tpfl_if and tlv_packet_field_locator_core
module tlv_packet_field_locator_core_tb;
    import tpfl_pkg::*;

    typedef enum logic [3:0] {
        R_FIXED, R_PERHOP, R_MESSAGE, R_INTEREST, R_OBJECT, R_VALALG,
        R_VALTYPE, R_SIGPARAM, R_IDLE, R_DISCARD
    } t_region;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tpfl_in_if  in_ch();
    tpfl_out_if out_ch();

    tlv_packet_field_locator_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, one packet at a time
    int unsigned pos, type_byte, hdr_end, pkt_end, tl_word, tlv_start;
    int unsigned cont_end, inner_lim, found, err;
    t_region     region;

    t_rec        expected_recs[$];
    t_rec        step_recs[$];
    int          fail_count = 0;
    int          rec_count = 0;
    int          done_count = 0;
    int          packets_sent = 0;
    bit          stim_done = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_off = 1'b0;

    task automatic report(input string what, input t_rec got, input t_rec want);
        fail_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    function automatic void emit_rec(input logic [3:0] k, input int unsigned off,
                                     input int unsigned len, input logic [2:0] st);
        t_rec r;
        if (step_recs.size() >= 2) return;
        r.record_kind    = k;
        r.field_offset   = off[15:0];
        r.field_length   = len[15:0];
        r.packet_kind    = type_byte[7:0];
        r.parse_status   = st;
        r.last_of_packet = (k == K_DONE);
        step_recs.push_back(r);
    endfunction

    function automatic void clear_packet();
        pos = 0; type_byte = 0; hdr_end = 0; pkt_end = 0; region = R_FIXED;
        tl_word = 0; tlv_start = 0; cont_end = 0; inner_lim = 0; found = 0; err = 0;
    endfunction

    // step into a walk level, dropping to the next one while no tl header fits
    function automatic void descend(input t_region m, input int unsigned start);
        bit stay;
        stay = 1'b0;
        while (!stay) begin
            region = m;
            tlv_start = start;
            case (m)
                R_PERHOP: begin
                    if (start + 4 < hdr_end) stay = 1'b1;
                    else begin m = R_MESSAGE; start = hdr_end; end
                end
                R_MESSAGE, R_VALALG: begin
                    if (start + 4 < pkt_end) stay = 1'b1;
                    else m = R_IDLE;
                end
                R_INTEREST: begin
                    if (found < 3 && start + 4 <= cont_end) stay = 1'b1;
                    else begin m = R_VALALG; start = cont_end; end
                end
                R_OBJECT: begin
                    if (found < 2 && start + 4 <= cont_end) stay = 1'b1;
                    else begin m = R_VALALG; start = cont_end; end
                end
                R_VALTYPE: begin
                    if (start + 4 < cont_end) stay = 1'b1;
                    else m = R_IDLE;
                end
                R_SIGPARAM: begin
                    if (start + 4 < inner_lim) stay = 1'b1;
                    else m = R_IDLE;
                end
                default: stay = 1'b1;
            endcase
        end
    endfunction

    // a complete 4-byte tl header at the current level
    function automatic void take_tl();
        int unsigned t, len, v, e;
        logic [3:0]  k;
        bit          hit;
        t = tl_word >> 16;
        len = tl_word & 16'hFFFF;
        v = tlv_start + 4;
        e = v + len;
        case (region)
            R_PERHOP: begin
                if (e <= hdr_end) begin
                    if (t == T_01) emit_rec(K_LIFETIME, v, len, ST_OK);
                    else if (t == T_02) emit_rec(K_CACHETIME, v, len, ST_OK);
                end
                descend(R_PERHOP, e);
            end
            R_MESSAGE: begin
                if (e > pkt_end) descend(R_IDLE, e);
                else begin
                    cont_end = e;
                    found = 0;
                    if (t == T_01) descend(R_INTEREST, v);
                    else if (t == T_02 || t == T_06) descend(R_OBJECT, v);
                    else begin
                        if (t == T_CPI) emit_rec(K_CPI, v, len, ST_OK);
                        else if (t == T_05) emit_rec(K_FRAGMENT, v, len, ST_OK);
                        descend(R_VALALG, e);
                    end
                end
            end
            R_INTEREST, R_OBJECT: begin
                if (e <= cont_end) begin
                    hit = 1'b1;
                    if (t == T_ZERO) k = K_NAME;
                    else if (region == R_INTEREST && t == T_02) k = K_KEYID;
                    else if (region == R_INTEREST && t == T_03) k = K_OBJHASH;
                    else if (region == R_OBJECT && t == T_06) k = K_EXPIRY;
                    else hit = 1'b0;
                    if (hit) begin
                        emit_rec(k, v, len, ST_OK);
                        found++;
                    end
                end
                descend(region, e);
            end
            R_VALALG: begin
                if (e <= pkt_end && t == T_03) begin
                    cont_end = e;
                    descend(R_VALTYPE, v);
                end else descend(R_IDLE, e);
            end
            R_VALTYPE: begin
                if (e <= cont_end && (t == T_06 || t == T_07 || t == T_08)) begin
                    inner_lim = e;
                    descend(R_SIGPARAM, v);
                end else descend(R_IDLE, e);
            end
            R_SIGPARAM: begin
                if (e <= inner_lim) begin
                    if (t == T_09) emit_rec(K_KEYID, v, len, ST_OK);
                    else if (t == T_0C) emit_rec(K_CERT, v, len, ST_OK);
                    else if (t == T_0B) emit_rec(K_PUBKEY, v, len, ST_OK);
                end
                descend(R_SIGPARAM, e);
            end
            default: ;
        endcase
    endfunction

    // records caused by one accepted byte, left in step_recs
    function automatic void locate_fields(input logic [7:0] b, input logic fend);
        int unsigned p;
        p = pos & 16'hFFFF;
        step_recs.delete();
        if (region == R_DISCARD) begin
            if (fend) clear_packet();
            return;
        end
        if (region == R_FIXED) begin
            if (p == 0 && b != 8'd1) err = ST_BAD_VER;
            else if (p == 1) type_byte = b;
            else if (p == 2) pkt_end = b << 8;
            else if (p == 3) pkt_end |= b;
            else if (p == 7) begin
                hdr_end = b;
                if (err == 0) begin
                    if (!(type_byte inside {0, 1, 2, 4, PT_A4})) err = ST_BAD_TYPE;
                    else if (hdr_end < 8) err = ST_SHORT_HDR;
                    else if (pkt_end < hdr_end) err = ST_LEN_BELOW;
                end
                if (err != 0) begin
                    emit_rec(K_DONE, 0, 0, err[2:0]);
                    if (fend) clear_packet(); else region = R_DISCARD;
                    return;
                end
                if (type_byte == 0) emit_rec(K_HOPLIMIT, 4, 1, ST_OK);
                descend(R_PERHOP, 8);
            end
            if (region == R_FIXED) begin
                if (fend) begin
                    emit_rec(K_DONE, 0, 0, ST_TRUNC);
                    clear_packet();
                end else pos = p + 1;
                return;
            end
        end else if (region != R_IDLE && p >= tlv_start && p - tlv_start < 4) begin
            tl_word = (tl_word << 8) | b;
            if (p - tlv_start == 3) take_tl();
        end
        if (p + 1 == pkt_end) begin
            emit_rec(K_DONE, 0, 0, ST_OK);
            if (fend) clear_packet(); else region = R_DISCARD;
        end else if (fend) begin
            emit_rec(K_DONE, 0, 0, ST_TRUNC);
            clear_packet();
        end else pos = (p + 1) & 16'hFFFF;
    endfunction

    // byte stream to send, each byte with its frame-end flag
    typedef struct {
        logic [7:0] b;
        logic       fend;
    } t_beat;
    t_beat byte_q[$];

    function automatic void push_byte(input int unsigned b, input bit fend);
        t_beat x;
        x.b = b[7:0];
        x.fend = fend;
        byte_q.push_back(x);
    endfunction

    function automatic void push_tl(input int unsigned t, input int unsigned len);
        push_byte(t >> 8, 0); push_byte(t, 0); push_byte(len >> 8, 0); push_byte(len, 0);
    endfunction

    // mostly well-formed packet with random content; cut ends it short or pads it
    function automatic void build_packet();
        int unsigned pt, hl, bl, body[$], i, n, ty, ln, sub, cut, mode;
        int unsigned types[5] = '{0, 1, 2, 4, 8'hA4};
        body.delete();
        pt = types[$urandom_range(0, 4)];
        // per-hop part
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
            ty = $urandom_range(0, 3);
            ln = $urandom_range(0, 3);
            body.push_back(0); body.push_back(ty); body.push_back(0); body.push_back(ln);
            repeat (ln) body.push_back($urandom_range(0, 255));
        end
        if ($urandom_range(0, 7) == 0) body.push_back($urandom_range(0, 255));
        hl = 8 + body.size();
        // message container
        mode = $urandom_range(0, 5);
        ty = (mode == 0) ? 1 : (mode == 1) ? 2 : (mode == 2) ? 6 :
             (mode == 3) ? 16'hBEEF : (mode == 4) ? 5 : $urandom_range(0, 16'hFFFF);
        begin
            int unsigned inner[$];
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) begin
                sub = $urandom_range(0, 7);
                ln = $urandom_range(0, 3);
                inner.push_back(0); inner.push_back(sub); inner.push_back(0);
                inner.push_back(ln);
                repeat (ln) inner.push_back($urandom_range(0, 255));
            end
            if ($urandom_range(0, 5) == 0) inner.push_back($urandom_range(0, 255));
            ln = inner.size();
            if ($urandom_range(0, 9) == 0) ln = ln + $urandom_range(1, 4);
            body.push_back(ty >> 8); body.push_back(ty & 8'hFF);
            body.push_back(ln >> 8); body.push_back(ln & 8'hFF);
            foreach (inner[j]) body.push_back(inner[j]);
        end
        // validation part
        if ($urandom_range(0, 3) != 0) begin
            int unsigned sp[$];
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                sub = $urandom_range(0, 3);
                sub = (sub == 0) ? 9 : (sub == 1) ? 11 : (sub == 2) ? 12 : $urandom_range(0, 15);
                ln = $urandom_range(0, 3);
                sp.push_back(0); sp.push_back(sub); sp.push_back(0); sp.push_back(ln);
                repeat (ln) sp.push_back($urandom_range(0, 255));
            end
            ln = sp.size();
            body.push_back(0); body.push_back(3); body.push_back(0); body.push_back(ln + 4);
            body.push_back(0); body.push_back($urandom_range(5, 9));
            body.push_back(0); body.push_back(ln);
            foreach (sp[j]) body.push_back(sp[j]);
        end
        bl = 8 + body.size();
        if ($urandom_range(0, 9) == 0) bl = bl - $urandom_range(0, body.size());
        cut = bl + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, bl);
        begin
            int unsigned all[$];
            all = '{1, pt, bl >> 8, bl & 8'hFF, $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), hl};
            foreach (body[j]) all.push_back(body[j]);
            while (all.size() < cut) all.push_back($urandom_range(0, 255));
            for (i = 0; i < cut; i++) push_byte(all[i], i == cut - 1);
        end
    endfunction

    // random bytes, frame end at the close
    function automatic void build_noise();
        int unsigned n, i;
        n = $urandom_range(1, 14);
        for (i = 0; i < n; i++)
            push_byte((i == 0 && $urandom_range(0, 1)) ? 1 : $urandom_range(0, 255), i == n - 1);
    endfunction

    // directed table: header errors, extremes and early ends
    typedef struct {
        logic [7:0] b;
        logic       fend;
        logic       chk;
        t_rec       want;
    } t_row;
    t_row dir_rows[$];

    function automatic t_rec done_rec(input int unsigned pt, input logic [2:0] st);
        t_rec r;
        r = '{K_DONE, 16'd0, 16'd0, pt[7:0], st, 1'b1};
        return r;
    endfunction

    function automatic void add_row(input int unsigned b, input bit fend,
                                    input bit chk, input t_rec want);
        t_row r;
        r.b = b[7:0];
        r.fend = fend;
        r.chk = chk;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    initial begin
        t_rec none;
        none = '0;
        // bad version, extremes 0xff, frame end inside header
        add_row(8'hFF, 0, 0, none); add_row(0, 0, 0, none); add_row(0, 0, 0, none);
        add_row(0, 0, 0, none); add_row(0, 0, 0, none); add_row(0, 0, 0, none);
        add_row(0, 0, 0, none); add_row(8'hFF, 0, 1, done_rec(0, ST_BAD_VER));
        add_row(8'hFF, 1, 0, none);
        // truncated on second header byte, which is the type byte
        add_row(1, 0, 0, none); add_row(8'h55, 1, 1, done_rec(8'h55, ST_TRUNC));
        // bad type, then short header
        add_row(1, 0, 0, none); add_row(3, 0, 0, none); add_row(0, 0, 0, none);
        add_row(8'h10, 0, 0, none); add_row(0, 0, 0, none); add_row(0, 0, 0, none);
        add_row(0, 0, 0, none); add_row(8, 1, 1, done_rec(3, ST_BAD_TYPE));
        add_row(1, 0, 0, none); add_row(8'hA4, 0, 0, none); add_row(8'hFF, 0, 0, none);
        add_row(8'hFF, 0, 0, none); add_row(0, 0, 0, none); add_row(0, 0, 0, none);
        add_row(0, 0, 0, none); add_row(7, 1, 1, done_rec(8'hA4, ST_SHORT_HDR));
    end

    // sender: directed rows first, then random packets
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.frame_end = 1'b0;
        clear_packet();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].fend);
        // length below header, and a full interest with hop limit
        push_byte(1, 0); push_byte(2, 0); push_byte(0, 0); push_byte(9, 0);
        push_byte(0, 0); push_byte(0, 0); push_byte(0, 0); push_byte(12, 1);
        push_byte(1, 0); push_byte(0, 0); push_byte(0, 0); push_byte(31, 0);
        push_byte(0, 0); push_byte(0, 0); push_byte(0, 0); push_byte(8, 0);
        push_tl(1, 11); push_tl(0, 1); push_byte(8'h80, 0); push_tl(2, 2);
        push_byte(0, 0); push_byte(0, 1);
        while (packets_sent < 58 || byte_q.size() != 0) begin
            if (byte_q.size() == 0) begin
                if ($urandom_range(0, 9) < 8) build_packet(); else build_noise();
                packets_sent++;
                no_idle = (packets_sent > 30 && packets_sent < 45);
                if (packets_sent == 20) hold_off = 1'b1;
            end
            if (!no_idle && $urandom_range(0, 99) < 36) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                in_ch.valid <= 1'b1;
                in_ch.data_byte <= byte_q[0].b;
                in_ch.frame_end <= byte_q[0].fend;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                void'(byte_q.pop_front());
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off
    initial begin
        int unsigned n;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                hold_off = 1'b0;
                out_ch.ready <= 1'b0;
                for (n = 0; n < 60; n++) @(posedge i_clk);
            end
            out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 36);
        end
    end

    // predict on accepted bytes, check accepted records
    int unsigned dir_idx = 0;
    int unsigned quiet = 0;
    always @(posedge i_clk) begin
        t_rec got, want;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                locate_fields(in_ch.data_byte, in_ch.frame_end);
                if (dir_idx < dir_rows.size()) begin
                    if (dir_rows[dir_idx].chk && (step_recs.size() != 1 ||
                        step_recs[0] !== dir_rows[dir_idx].want))
                        report("directed row", step_recs.size() ? step_recs[0] : '0,
                               dir_rows[dir_idx].want);
                    dir_idx++;
                end
                foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                got = '{out_ch.record_kind, out_ch.field_offset, out_ch.field_length,
                        out_ch.packet_kind, out_ch.parse_status, out_ch.last_of_packet};
                rec_count++;
                if (got.last_of_packet) done_count++;
                if (expected_recs.size() == 0) report("unexpected record", got, '0);
                else begin
                    want = expected_recs.pop_front();
                    if (got.record_kind !== want.record_kind) report("kind", got, want);
                    else if (got.field_offset !== want.field_offset) report("offset", got, want);
                    else if (got.field_length !== want.field_length) report("length", got, want);
                    else if (got.packet_kind !== want.packet_kind) report("pkt kind", got, want);
                    else if (got.parse_status !== want.parse_status) report("status", got, want);
                    else if (got.last_of_packet !== want.last_of_packet)
                        report("last", got, want);
                end
            end
            quiet <= moved ? 0 : quiet + 1;
        end
    end

    // end of run and watchdog
    initial begin
        wait (stim_done && expected_recs.size() == 0);
        repeat (10) @(posedge i_clk);
        if (expected_recs.size() != 0) fail_count++;
        $display("sent %0d packets, checked %0d records (%0d packet closes)",
                 packets_sent, rec_count, done_count);
        if (fail_count == 0) $display("** tlv_packet_field_locator_core: PASSED **");
        else $display("** tlv_packet_field_locator_core: FAILED **");
        $finish;
    end

    initial begin
        wait (quiet >= WATCHDOG_LIMIT);
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("** tlv_packet_field_locator_core: FAILED **");
        $finish;
    end

endmodule

### tlv_packet_field_locator_core.f
hdl/tpfl_pkg.sv
hdl/tpfl_if.sv
hdl/tpfl_parser.sv
hdl/tpfl_out_fifo.sv
hdl/tlv_packet_field_locator_core.sv
tb/tlv_packet_field_locator_core_tb.sv
